// File: sv/rdse_pkg.sv
// Shared constants and helpers for the radix digit string emitter.
`default_nettype none
package rdse_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A        = 7'd97;  // 'a'
  localparam logic [RADIX_W-1:0] DEC_DIGIT_MAX = 6'd9;

  // Map a digit value 0..35 onto '0'..'9', 'a'..'z'.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d <= DEC_DIGIT_MAX) begin
      digit_to_char = CHAR_ZERO + dx;
    end else begin
      digit_to_char = CHAR_A + dx - CHAR_W'(DEC_DIGIT_MAX + 6'd1);
    end
  endfunction

  // Clamp the base into 2..36.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      sat_radix = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      sat_radix = RADIX_MAX;
    end else begin
      sat_radix = r;
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/radix_digit_string_emitter_core.sv
// Top level: converts one integer per beat into its digit string in base 2..36.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in      | input     | in_valid / in_stall | number[VALUE_BITS], radix[6]
//   out     | output    | out_valid/out_stall | digit_char[7], last
//
// Each digit is formed bit-serially by a restoring divider (one quotient bit
// per cycle); digits are produced until the quotient is zero.
// Each character then passes through the RAM read, load and show states, the
// padding '0' through read and show only; the show state holds while the
// output stalls.
// Synchronous active-high reset returns the sequencer to idle; the input
// stalls during reset and from acceptance until the last character beat is taken.
`default_nettype none
module radix_digit_string_emitter_core #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [VALUE_BITS-1:0]       number,
  input  wire logic [rdse_pkg::RADIX_W-1:0] radix,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [rdse_pkg::CHAR_W-1:0] digit_char,
  output logic                             last
);

  localparam int DEPTH = VALUE_BITS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(VALUE_BITS);
  localparam int RW    = rdse_pkg::RADIX_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_WAIT = 5'b01000,
    S_SHOW = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [VALUE_BITS-1:0] quo;
  logic [RW-1:0]         rem;
  logic [RW-1:0]         base;
  logic [BW-1:0]         bit_cnt;
  logic [AW-1:0]         dcount;
  logic                  lead;

  logic [RW:0]           trial;
  logic                  ge;
  logic [RW-1:0]         rem_next;
  logic [VALUE_BITS-1:0] quo_next;
  logic                  digit_done;
  logic                  ram_we;
  logic [RW-1:0]         ram_rdata;
  logic                  in_fire;

  assign in_stall = rst || (state != S_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign out_valid = (state == S_SHOW);

  // One restoring division step: shift in the next dividend bit.
  assign trial      = {rem, quo[VALUE_BITS-1]};
  assign ge         = (trial >= {1'b0, base});
  assign rem_next   = ge ? RW'(trial - {1'b0, base}) : trial[RW-1:0];
  assign quo_next   = {quo[VALUE_BITS-2:0], ge};
  assign digit_done = (state == S_DIV) && (bit_cnt == BW'(VALUE_BITS - 1));
  assign ram_we     = digit_done;

  rdse_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dcount),
    .wdata (rem_next),
    .raddr (dcount - AW'(1)),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        if (digit_done && (quo_next == '0)) state_next = S_RD;
      end
      S_RD: begin
        state_next = lead ? S_SHOW : S_WAIT;
      end
      S_WAIT: begin
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) state_next = last ? S_IDLE : S_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      quo     <= number;
      rem     <= '0;
      base    <= rdse_pkg::sat_radix(radix);
      bit_cnt <= '0;
      dcount  <= '0;
      lead    <= (number <= VALUE_BITS'(rdse_pkg::DEC_DIGIT_MAX));
    end
    if (state == S_DIV) begin
      quo <= quo_next;
      if (digit_done) begin
        // Start the next digit on the quotient just formed.
        rem     <= '0;
        bit_cnt <= '0;
        dcount  <= dcount + AW'(1);
      end else begin
        rem     <= rem_next;
        bit_cnt <= bit_cnt + BW'(1);
      end
    end
    if (state == S_RD && lead) begin
      digit_char <= rdse_pkg::CHAR_ZERO;
      last       <= 1'b0;
      lead       <= 1'b0;
    end
    if (state == S_WAIT) begin
      digit_char <= rdse_pkg::digit_to_char(ram_rdata);
      last       <= (dcount == AW'(1));
      dcount     <= dcount - AW'(1);
    end
  end

endmodule
`default_nettype wire

// File: sv/rdse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rdse_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/radix_digit_string_emitter_core_tb.sv
// Self-checking testbench for the radix digit string emitter core.
`default_nettype none
module radix_digit_string_emitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS  = 31;
  localparam int IDLE_LIMIT  = 6000;
  localparam int LONG_HOLD   = 500;
  localparam int RANDOM_HALF = 180;

  typedef struct {
    logic [VALUE_BITS-1:0]          num;
    logic [rdse_pkg::RADIX_W-1:0]   rad;
  } number_item_t;

  typedef struct {
    logic [rdse_pkg::CHAR_W-1:0] ch;
    logic                        fin;
  } char_beat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [VALUE_BITS-1:0]        number = '0;
  logic [rdse_pkg::RADIX_W-1:0] radix = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [rdse_pkg::CHAR_W-1:0]  digit_char;
  logic                         last;

  number_item_t item_q[$];
  char_beat_t   expected_chars[$];
  number_item_t next_item;

  int numbers_queued = 0;
  int numbers_taken  = 0;
  int chars_checked  = 0;
  int mismatch_count = 0;
  int clamped_radix  = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int stall_mode     = 0;
  int mode_timer     = 0;
  int pattern_cyc    = 0;
  bit first_hold_done  = 1'b0;
  bit second_hold_done = 1'b0;
  bit beat_bad         = 1'b0;

  radix_digit_string_emitter_core #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .radix     (radix),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit_char(digit_char),
    .last      (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Build the expected character string of one number, most significant digit first.
  function automatic void predict_digit_string(input logic [VALUE_BITS-1:0] value,
                                               input logic [rdse_pkg::RADIX_W-1:0] base_in);
    longint unsigned  quot;
    int unsigned      base;
    int unsigned      digits[$];
    int unsigned      d;
    char_beat_t       beat;
    base = base_in;
    if (base < 2) base = 2;
    if (base > 36) base = 36;
    if (value == '0) begin
      beat.ch = rdse_pkg::CHAR_ZERO; beat.fin = 1'b0;
      expected_chars.push_back(beat);
      beat.fin = 1'b1;
      expected_chars.push_back(beat);
    end else begin
      quot = value;
      while (quot != 0) begin
        digits.push_front(int'(quot % base));
        quot = quot / base;
      end
      // single decimal-size values get a padding zero in any base
      if (value <= 9) begin
        beat.ch = rdse_pkg::CHAR_ZERO; beat.fin = 1'b0;
        expected_chars.push_back(beat);
      end
      for (int i = 0; i < digits.size(); i++) begin
        d = digits[i];
        beat.ch  = (d <= 9) ? rdse_pkg::CHAR_ZERO + rdse_pkg::CHAR_W'(d)
                            : rdse_pkg::CHAR_A + rdse_pkg::CHAR_W'(d - 10);
        beat.fin = (i == digits.size() - 1);
        expected_chars.push_back(beat);
      end
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_number();
    int unsigned      sel;
    int unsigned      bits;
    logic [VALUE_BITS-1:0] v;
    sel = $urandom_range(99, 0);
    if (sel < 15) begin
      v = VALUE_BITS'($urandom_range(9, 0));
    end else if (sel < 20) begin
      v = '1;
    end else begin
      // bias toward short values so wide base-2 conversions stay a minority
      bits = $urandom_range(VALUE_BITS, 1);
      v = VALUE_BITS'($urandom) & VALUE_BITS'((64'd1 << bits) - 1);
    end
    return v;
  endfunction

  function automatic logic [rdse_pkg::RADIX_W-1:0] random_radix();
    if ($urandom_range(99, 0) < 85) return rdse_pkg::RADIX_W'($urandom_range(36, 2));
    return rdse_pkg::RADIX_W'($urandom_range(63, 0));
  endfunction

  task automatic queue_number(input logic [VALUE_BITS-1:0] v,
                              input logic [rdse_pkg::RADIX_W-1:0] r);
    number_item_t it;
    it.num = v;
    it.rad = r;
    item_q.push_back(it);
    numbers_queued++;
  endtask

  task automatic wait_drained();
    while (numbers_taken != numbers_queued || expected_chars.size() != 0) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_digit_string(number, radix);
        numbers_taken <= numbers_taken + 1;
        if (radix < rdse_pkg::RADIX_MIN || radix > rdse_pkg::RADIX_MAX) begin
          clamped_radix <= clamped_radix + 1;
        end
      end
      // hold the payload while stalled
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          next_item = item_q.pop_front();
          number   <= next_item.num;
          radix    <= next_item.rad;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(12, 1);
            gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotating stall patterns plus two long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      pattern_cyc <= pattern_cyc + 1;
      if (mode_timer == 0) begin
        stall_mode <= $urandom_range(3, 0);
        mode_timer <= $urandom_range(200, 40);
      end else begin
        mode_timer <= mode_timer - 1;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (numbers_taken == 120 && !first_hold_done) begin
        first_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (numbers_taken == 300 && !second_hold_done) begin
        second_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= 1'($urandom_range(1, 0));
          end
          2: begin
            out_stall <= ($urandom_range(6, 0) != 0);
          end
          default: begin
            out_stall <= (pattern_cyc % 5) < 2;
          end
        endcase
      end
    end
  end

  // Check each character beat against the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: digit_char %0d last %0d", digit_char, last);
        mismatch_count <= mismatch_count + 1;
      end else begin
        beat_bad = 1'b0;
        if (digit_char !== expected_chars[0].ch) begin
          $error("digit_char mismatch: expected %0d actual %0d",
                 expected_chars[0].ch, digit_char);
          beat_bad = 1'b1;
        end
        if (last !== expected_chars[0].fin) begin
          $error("last mismatch: expected %0d actual %0d", expected_chars[0].fin, last);
          beat_bad = 1'b1;
        end
        if (beat_bad) mismatch_count <= mismatch_count + 1;
        void'(expected_chars.pop_front());
        chars_checked <= chars_checked + 1;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles with no beat", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, padded small values, digit extremes, widest values, clamped bases
    queue_number(0, 10);
    queue_number(0, 2);
    queue_number(1, 2);
    queue_number(5, 10);
    queue_number(9, 36);
    queue_number(9, 2);
    queue_number(10, 10);
    queue_number(35, 36);
    queue_number(36, 36);
    queue_number(255, 16);
    queue_number('1, 2);
    queue_number('1, 3);
    queue_number('1, 36);
    queue_number('1, 10);
    queue_number(31'h2aaa_aaaa, 8);
    queue_number(31'h5555_5555, 16);
    queue_number(100, 0);
    queue_number(100, 1);
    queue_number(1295, 37);
    queue_number(1, 63);
    queue_number(0, 63);
    queue_number(31'h4000_0000, 35);
    wait_drained();

    for (int i = 0; i < RANDOM_HALF; i++) queue_number(random_number(), random_radix());
    // pause the sender until every expected character is back
    wait_drained();
    for (int i = 0; i < RANDOM_HALF; i++) queue_number(random_number(), random_radix());
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Converted %0d numbers (%0d with a clamped base) into %0d checked characters,",
             numbers_taken, clamped_radix, chars_checked);
    $display("with bursty input, varied output stalls, two long hold-offs and a drain pause.");
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: radix_digit_string_emitter_core.f
sv/rdse_pkg.sv
sv/rdse_ram.sv
sv/radix_digit_string_emitter_core.sv
tb/radix_digit_string_emitter_core_tb.sv
